@@ hdl/m3i_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants of the 3x3 matrix inverse
// Element count, row length and the per-item flag bundle that travels with
// each matrix through the divide pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int NUM_ELEM = 9;
	localparam int ROW_LEN  = 3;

	// Per-item status carried alongside the quotients.
	typedef struct packed {
		logic                sing; // determinant is exactly zero
		logic [NUM_ELEM-1:0] neg;  // sign of each result entry
		logic [NUM_ELEM-1:0] ovf;  // magnitude known to exceed the quotient width
	} m3i_flags_t;

endpackage

@@ hdl/m3i_cofactor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_cofactor: adjugate cofactor stages
// Stage 1 forms the eighteen element products, stage 2 the nine exact
// 2x2 cofactor differences. The first matrix row travels along for the
// determinant.
// ----------------------------------------------------------------------------
module m3i_cofactor import m3i_pkg::*; #(
	parameter int W = 24
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [W-1:0]    m   [NUM_ELEM],
	output logic signed [2*W:0]    p   [NUM_ELEM],
	output logic signed [W-1:0]    row [ROW_LEN]
);

	localparam int PW = 2*W+1;

	// Entry i of the adjugate is m[A]*m[B] - m[C]*m[D].
	localparam int COF_A [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int COF_B [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int COF_C [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int COF_D [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	logic signed [2*W-1:0] pa_s1  [NUM_ELEM];
	logic signed [2*W-1:0] pc_s1  [NUM_ELEM];
	logic signed [W-1:0]   row_s1 [ROW_LEN];
	logic signed [PW-1:0]  p_s2   [NUM_ELEM];
	logic signed [W-1:0]   row_s2 [ROW_LEN];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				pa_s1[i] <= m[COF_A[i]] * m[COF_B[i]];
				pc_s1[i] <= m[COF_C[i]] * m[COF_D[i]];
			end
			for (int j = 0; j < ROW_LEN; j++) begin
				row_s1[j] <= m[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				p_s2[i] <= PW'(pa_s1[i]) - PW'(pc_s1[i]);
			end
			row_s2 <= row_s1;
		end
	end

	assign p   = p_s2;
	assign row = row_s2;

endmodule

@@ hdl/m3i_det.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_det: determinant and divide setup
// Stages 3 to 7: split multiplies of the first row by its cofactors, the
// determinant sum, its magnitude, and the dividend, divisor and singular
// rounding that seed the bit-serial divide pipeline.
// ----------------------------------------------------------------------------
module m3i_det import m3i_pkg::*; #(
	parameter int W  = 24,
	parameter int F  = 16,
	parameter int QW = 25,
	parameter int CW = 101
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [2*W:0]  p     [NUM_ELEM],
	input  logic signed [W-1:0]  row   [ROW_LEN],
	output logic [CW-1:0]        x     [NUM_ELEM],
	output logic [CW-1:0]        y,
	output logic [QW-1:0]        q     [NUM_ELEM],
	output m3i_flags_t           flags
);

	localparam int PW = 2*W+1;
	localparam int DW = 3*W+3;

	logic signed [2*W+1:0] pplo_s3 [ROW_LEN];
	logic signed [2*W-1:0] pphi_s3 [ROW_LEN];
	logic [PW-1:0]         nmag_s3 [NUM_ELEM];
	logic [NUM_ELEM-1:0]   aneg_s3;

	logic signed [DW-1:0]  term_s4 [ROW_LEN];
	logic [PW-1:0]         nmag_s4 [NUM_ELEM];
	logic [NUM_ELEM-1:0]   aneg_s4;

	logic signed [DW-1:0]  det_s5;
	logic [PW-1:0]         nmag_s5 [NUM_ELEM];
	logic [NUM_ELEM-1:0]   aneg_s5;

	logic [DW-1:0]         dmag_s6;
	logic                  dneg_s6;
	logic                  sing_s6;
	logic [PW-1:0]         nmag_s6 [NUM_ELEM];
	logic [NUM_ELEM-1:0]   aneg_s6;

	logic [CW-1:0]         x_s7 [NUM_ELEM];
	logic [CW-1:0]         y_s7;
	logic [QW-1:0]         q_s7 [NUM_ELEM];
	m3i_flags_t            flags_s7;

	logic [CW-1:0]         trnd [NUM_ELEM];

	// The cofactor is split into an unsigned low part and a signed high part
	// so that each multiplier stays near W by W bits.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < ROW_LEN; j++) begin
				pplo_s3[j] <= row[j] * $signed({1'b0, p[ROW_LEN*j][W:0]});
				pphi_s3[j] <= row[j] * $signed(p[ROW_LEN*j][PW-1:W+1]);
			end
			for (int i = 0; i < NUM_ELEM; i++) begin
				nmag_s3[i] <= p[i][PW-1] ? PW'(-p[i]) : PW'(p[i]);
				aneg_s3[i] <= p[i][PW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < ROW_LEN; j++) begin
				term_s4[j] <= (DW'(pphi_s3[j]) <<< (W+1)) + DW'(pplo_s3[j]);
			end
			nmag_s4 <= nmag_s3;
			aneg_s4 <= aneg_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5  <= term_s4[0] + term_s4[1] + term_s4[2];
			nmag_s5 <= nmag_s4;
			aneg_s5 <= aneg_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			dneg_s6 <= det_s5[DW-1];
			sing_s6 <= (det_s5 == '0);
			nmag_s6 <= nmag_s5;
			aneg_s6 <= aneg_s5;
		end
	end

	// Adjugate entry rounded to F fraction bits, used when singular.
	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			trnd[i] = (CW'(nmag_s6[i]) + (CW'(1) << (F-1))) >> F;
		end
	end

	// Dividend 2N*2^(2F) + D and divisor 2D give the rounded quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				x_s7[i]           <= (CW'(nmag_s6[i]) << (2*F+1)) + CW'(dmag_s6);
				q_s7[i]           <= sing_s6 ? trnd[i][QW-1:0] : '0;
				flags_s7.neg[i]   <= sing_s6 ? aneg_s6[i] : (aneg_s6[i] ^ dneg_s6);
				flags_s7.ovf[i]   <= sing_s6 && ((trnd[i] >> QW) != '0);
			end
			y_s7          <= CW'(dmag_s6) << 1;
			flags_s7.sing <= sing_s6;
		end
	end

	assign x     = x_s7;
	assign y     = y_s7;
	assign q     = q_s7;
	assign flags = flags_s7;

endmodule

@@ hdl/m3i_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_div_step: one restoring divide stage for all nine lanes
// Compares each remainder with the divisor shifted by K. The top stage only
// detects quotients too wide to represent; the others retire quotient bit K.
// ----------------------------------------------------------------------------
module m3i_div_step import m3i_pkg::*; #(
	parameter int CW = 101,
	parameter int QW = 25,
	parameter int K  = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [CW-1:0] r_in      [NUM_ELEM],
	input  logic [CW-1:0] y_in,
	input  logic [QW-1:0] q_in      [NUM_ELEM],
	input  m3i_flags_t    flags_in,
	output logic [CW-1:0] r_out     [NUM_ELEM],
	output logic [CW-1:0] y_out,
	output logic [QW-1:0] q_out     [NUM_ELEM],
	output m3i_flags_t    flags_out
);

	logic [CW-1:0]       ys;
	logic [NUM_ELEM-1:0] ge;
	logic [CW-1:0]       r_nx [NUM_ELEM];
	logic [QW-1:0]       q_nx [NUM_ELEM];
	m3i_flags_t          f_nx;

	logic [CW-1:0]       r_q  [NUM_ELEM];
	logic [CW-1:0]       y_q;
	logic [QW-1:0]       q_q  [NUM_ELEM];
	m3i_flags_t          f_q;

	assign ys = y_in << K;

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			ge[i] = !flags_in.sing && (r_in[i] >= ys);
		end
	end

	generate
		if (K == QW) begin : g_ovf
			always_comb begin
				r_nx       = r_in;
				q_nx       = q_in;
				f_nx       = flags_in;
				f_nx.ovf   = flags_in.ovf | ge;
			end
		end else begin : g_bit
			always_comb begin
				f_nx = flags_in;
				for (int i = 0; i < NUM_ELEM; i++) begin
					r_nx[i]    = ge[i] ? (r_in[i] - ys) : r_in[i];
					q_nx[i]    = q_in[i];
					q_nx[i][K] = q_in[i][K] | ge[i];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= r_nx;
			y_q <= y_in;
			q_q <= q_nx;
			f_q <= f_nx;
		end
	end

	assign r_out     = r_q;
	assign y_out     = y_q;
	assign q_out     = q_q;
	assign flags_out = f_q;

endmodule

@@ hdl/m3i_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_out: saturation and output buffer
// Clips each quotient to the signed element range, packs the beat and holds
// it in a two-entry buffer that decouples the pipeline from the consumer.
// ----------------------------------------------------------------------------
module m3i_out import m3i_pkg::*; #(
	parameter int W   = 24,
	parameter int QW  = 25,
	parameter int TDW = 216
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  logic [QW-1:0]  q [NUM_ELEM],
	input  m3i_flags_t     flags,
	output logic           full,
	output logic [TDW-1:0] tdata,
	output logic [1:0]     tuser,
	output logic           tvalid,
	input  logic           tready
);

	localparam int DATW = NUM_ELEM*W;
	localparam int EW   = DATW+2;

	logic [QW-1:0]   lim  [NUM_ELEM];
	logic [QW-1:0]   magc [NUM_ELEM];
	logic [QW-1:0]   val  [NUM_ELEM];
	logic [NUM_ELEM-1:0] neg;
	logic [NUM_ELEM-1:0] clip;
	logic [DATW-1:0] res;
	logic [EW-1:0]   ent_nx;

	logic [EW-1:0]   ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            rd;

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			// A zero result is never negative.
			neg[i]  = flags.neg[i] && (flags.ovf[i] || (q[i] != '0));
			lim[i]  = neg[i] ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
			clip[i] = flags.ovf[i] || (q[i] > lim[i]);
			magc[i] = clip[i] ? lim[i] : q[i];
			val[i]  = neg[i] ? (QW'(0) - magc[i]) : magc[i];
			res[i*W +: W] = val[i][W-1:0];
		end
		ent_nx = {(|clip), flags.sing, res};
	end

	assign full   = (cnt_q == 2'd2);
	assign tvalid = (cnt_q != 2'd0);
	assign rd     = tvalid && tready;
	assign tdata  = TDW'(ent_q[rd_ptr_q][DATW-1:0]);
	assign tuser  = ent_q[rd_ptr_q][EW-1:DATW];

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_ptr_q] <= ent_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (cnt_q != 2'd2))
		else $error("write into a full output buffer");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("output buffer count did not rise on write");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("output buffer count did not fall on read");
`endif

endmodule

@@ hdl/matrix3x3_inverse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse: pipelined 3x3 matrix inverse in signed fixed point
// Inverts one row-major matrix per beat through its adjugate and determinant,
// with rounding to nearest and saturation to the element range.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake          Payload
// s_axis   in         s_tvalid/s_tready  s_tdata: m00..m22, W bits each
// m_axis   out        m_tvalid/m_tready  m_tdata: r00..r22; m_tuser: singular, saturated
//
// One matrix is accepted every cycle while the output buffer is not full. A
// beat passes through two cofactor stages, five determinant and setup stages,
// ELEM_WIDTH + 2 restoring divide stages (nine lanes side by side; the top one
// flags overflow, the rest retire one quotient bit each) and the output buffer.
// The divide chain sets the depth. Reset clears the valid bits and the output
// buffer only. When the consumer stalls, the two-entry output buffer fills and
// then the whole pipeline holds, so no beat is dropped or duplicated.
// ----------------------------------------------------------------------------
module matrix3x3_inverse import m3i_pkg::*; #(
	parameter int ELEM_WIDTH = 24,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
	input  logic [((NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22 from the lowest bit up
	output logic [((NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
	// singular, saturated from the lowest bit up
	output logic [1:0]                               m_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready
);

	localparam int W    = ELEM_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int TDW  = ((NUM_ELEM*W+7)/8)*8;
	// Quotient width: one bit beyond the element range to see clipping.
	localparam int QW   = W+1;
	localparam int PW   = 2*W+1;
	localparam int DW   = 3*W+3;
	localparam int XW0  = PW+2*F+1;
	localparam int XW   = ((XW0 > DW) ? XW0 : DW) + 1;
	localparam int CW   = (XW > DW+1+QW) ? XW : (DW+1+QW);
	localparam int NDIV = QW+1;
	localparam int NS   = 7+NDIV;

	logic               en;
	logic [NS-1:0]      vld_q;
	logic               full;
	logic               wr;

	logic signed [W-1:0]  m_in [NUM_ELEM];
	logic signed [PW-1:0] cof  [NUM_ELEM];
	logic signed [W-1:0]  row  [ROW_LEN];

	logic [CW-1:0]  r_d [NDIV][NUM_ELEM];
	logic [CW-1:0]  y_d [NDIV+1];
	logic [QW-1:0]  q_d [NDIV+1][NUM_ELEM];
	m3i_flags_t     f_d [NDIV+1];

	// The pipeline moves as one; it holds only while the output buffer is
	// full, which depends on registers alone and keeps the ready path short.
	assign en       = !full;
	assign s_tready = en;
	assign wr       = vld_q[NS-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], s_tvalid};
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			m_in[i] = s_tdata[i*W +: W];
		end
	end

	m3i_cofactor #(
		.W (W)
	) u_cof (
		.clk (clk),
		.en  (en),
		.m   (m_in),
		.p   (cof),
		.row (row)
	);

	m3i_det #(
		.W  (W),
		.F  (F),
		.QW (QW),
		.CW (CW)
	) u_det (
		.clk   (clk),
		.en    (en),
		.p     (cof),
		.row   (row),
		.x     (r_d[0]),
		.y     (y_d[0]),
		.q     (q_d[0]),
		.flags (f_d[0])
	);

	// Divide chain, most significant step first. The remainder of the last
	// step is not needed.
	generate
		for (genvar j = 0; j < NDIV; j++) begin : g_div
			if (j < NDIV-1) begin : g_mid
				m3i_div_step #(
					.CW (CW),
					.QW (QW),
					.K  (QW-j)
				) u_step (
					.clk       (clk),
					.en        (en),
					.r_in      (r_d[j]),
					.y_in      (y_d[j]),
					.q_in      (q_d[j]),
					.flags_in  (f_d[j]),
					.r_out     (r_d[j+1]),
					.y_out     (y_d[j+1]),
					.q_out     (q_d[j+1]),
					.flags_out (f_d[j+1])
				);
			end else begin : g_last
				m3i_div_step #(
					.CW (CW),
					.QW (QW),
					.K  (QW-j)
				) u_step (
					.clk       (clk),
					.en        (en),
					.r_in      (r_d[j]),
					.y_in      (y_d[j]),
					.q_in      (q_d[j]),
					.flags_in  (f_d[j]),
					.r_out     (),
					.y_out     (y_d[j+1]),
					.q_out     (q_d[j+1]),
					.flags_out (f_d[j+1])
				);
			end
		end
	endgenerate

	m3i_out #(
		.W   (W),
		.QW  (QW),
		.TDW (TDW)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.q      (q_d[NDIV]),
		.flags  (f_d[NDIV]),
		.full   (full),
		.tdata  (m_tdata),
		.tuser  (m_tuser),
		.tvalid (m_tvalid),
		.tready (m_tready)
	);

endmodule
